// File: hw/rtl/k_nearest_distance_insertion_top_defines.svh
// Assertion macros shared by the k-nearest distance insertion RTL.
`ifndef K_NEAREST_DISTANCE_INSERTION_TOP_DEFINES_SVH
`define K_NEAREST_DISTANCE_INSERTION_TOP_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define KND_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define KND_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/knd_pkg.sv
// Shared types and constants for the k-nearest distance insertion block.
`timescale 1ns / 1ps
`default_nettype none

package knd_pkg;

    localparam int MAX_NEIGHBORS_DEF = 8;
    localparam int COORD_BITS_DEF    = 16;
    localparam int DIST_BITS         = 34;
    localparam int RANK_BITS         = 3;
    localparam int CFG_BITS          = 4;

    typedef logic [DIST_BITS-1:0] t_dist;
    typedef logic [RANK_BITS-1:0] t_rank;
    typedef logic [CFG_BITS-1:0]  t_cfg;

    localparam t_dist DIST_ONES = {DIST_BITS{1'b1}};

    // Item command codes.
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_CAND  = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic start;       // load query point and empty the list
        logic diff_en;     // register coordinate differences of a candidate
        logic sq_en;       // register the two squares
        logic ins_en;      // insert the summed distance into the list
        logic emit_start;  // rewind the emit index
        logic out_load;    // load one result beat into the output register
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;    // output register empty or being taken this cycle
        logic emit_last;   // emit index points at the last active slot
    } t_status;

endpackage

`default_nettype wire

// File: hw/rtl/knd_ctrl.sv
// Controller state machine for the k-nearest distance insertion block.
`timescale 1ns / 1ps
`default_nettype none

module knd_ctrl (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_in_valid,
    input  wire              i_cmd,
    input  wire              i_final_item,
    input  knd_pkg::t_status i_status,
    output logic             o_in_ready,
    output knd_pkg::t_cmd    o_cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_INS  = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       r_final;
    logic       n_final;

    always_comb begin
        n_state    = r_state;
        n_final    = r_final;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_cmd == knd_pkg::CMD_START) begin
                        o_cmd.start = 1'b1;
                        if (i_final_item) begin
                            o_cmd.emit_start = 1'b1;
                            n_state          = ST_EMIT;
                        end
                    end else begin
                        o_cmd.diff_en = 1'b1;
                        n_final       = i_final_item;
                        n_state       = ST_MUL;
                    end
                end
            end
            ST_MUL: begin
                o_cmd.sq_en = 1'b1;
                n_state     = ST_INS;
            end
            ST_INS: begin
                o_cmd.ins_en = 1'b1;
                if (r_final) begin
                    o_cmd.emit_start = 1'b1;
                    n_state          = ST_EMIT;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    if (i_status.emit_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_final <= 1'b0;
        end else begin
            r_state <= n_state;
            r_final <= n_final;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/knd_dpath.sv
// Datapath: distance arithmetic, sorted list with insertion and output register.
`timescale 1ns / 1ps
`default_nettype none

module knd_dpath #(
    parameter int MAX_NEIGHBORS = knd_pkg::MAX_NEIGHBORS_DEF,
    parameter int COORD_BITS    = knd_pkg::COORD_BITS_DEF
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  knd_pkg::t_cmd               i_cmd,
    output knd_pkg::t_status            o_status,
    input  wire                         i_cfg_we,
    input  wire  [knd_pkg::CFG_BITS-1:0] i_cfg_wdata,
    input  wire  signed [COORD_BITS-1:0] i_pos_x,
    input  wire  signed [COORD_BITS-1:0] i_pos_y,
    input  wire                         i_out_ready,
    output logic                        o_out_valid,
    output knd_pkg::t_dist              o_distance,
    output knd_pkg::t_rank              o_rank,
    output logic                        o_filled,
    output logic                        o_end_of_run
);

    localparam int IDX_W = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;
    localparam int DIF_W = COORD_BITS + 1;
    localparam int SQ_W  = 2 * DIF_W;
    localparam int EXT_W = (SQ_W + 1 > knd_pkg::DIST_BITS) ? SQ_W + 1 : knd_pkg::DIST_BITS;

    logic signed [COORD_BITS-1:0] r_qx;
    logic signed [COORD_BITS-1:0] r_qy;
    logic signed [DIF_W-1:0]      r_dx;
    logic signed [DIF_W-1:0]      r_dy;
    logic [SQ_W-1:0]              r_sqx;
    logic [SQ_W-1:0]              r_sqy;
    knd_pkg::t_dist               r_list [MAX_NEIGHBORS];
    knd_pkg::t_dist               n_list [MAX_NEIGHBORS];
    logic [IDX_W-1:0]             r_idx;
    knd_pkg::t_cfg                r_neighbor_count;
    logic                         r_out_valid;
    knd_pkg::t_dist               r_out_dist;
    knd_pkg::t_rank               r_out_rank;
    logic                         r_out_filled;
    logic                         r_out_end;

    logic [7:0]                   k_clamp;
    logic [IDX_W-1:0]             last_idx;
    logic [DIF_W-1:0]             mag_x;
    logic [DIF_W-1:0]             mag_y;
    logic [EXT_W-1:0]             sum_ext;
    knd_pkg::t_dist               sd;
    logic [MAX_NEIGHBORS:0]       run;
    knd_pkg::t_dist               emit_dist;

    // Active slot count: zero acts as one, large values clamp to the list depth.
    always_comb begin
        k_clamp = 8'(r_neighbor_count);
        if (k_clamp == 8'd0) begin
            k_clamp = 8'd1;
        end else if (k_clamp > 8'(MAX_NEIGHBORS)) begin
            k_clamp = 8'(MAX_NEIGHBORS);
        end
        last_idx = IDX_W'(k_clamp - 8'd1);
    end

    assign mag_x = r_dx[DIF_W-1] ? DIF_W'(-r_dx) : DIF_W'(r_dx);
    assign mag_y = r_dy[DIF_W-1] ? DIF_W'(-r_dy) : DIF_W'(r_dy);

    // Sums that do not fit the distance width saturate to the empty marker.
    assign sum_ext = EXT_W'(r_sqx) + EXT_W'(r_sqy);
    assign sd      = (sum_ext > EXT_W'(knd_pkg::DIST_ONES)) ? knd_pkg::DIST_ONES
                                                            : knd_pkg::t_dist'(sum_ext);

    // A slot takes part when the new distance is below it and every active slot
    // behind it does too; the first such slot gets the new value, the rest shift.
    always_comb begin
        run[MAX_NEIGHBORS] = 1'b0;
        for (int i = MAX_NEIGHBORS - 1; i >= 0; i--) begin
            run[i] = (IDX_W'(i) <= last_idx) && (sd < r_list[i])
                     && ((IDX_W'(i) == last_idx) || run[i+1]);
        end
        n_list[0] = run[0] ? sd : r_list[0];
        for (int i = 1; i < MAX_NEIGHBORS; i++) begin
            if (run[i]) begin
                n_list[i] = run[i-1] ? r_list[i-1] : sd;
            end else begin
                n_list[i] = r_list[i];
            end
        end
    end

    assign emit_dist = r_list[r_idx];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qx             <= '0;
            r_qy             <= '0;
            r_neighbor_count <= knd_pkg::t_cfg'(1);
            r_out_valid      <= 1'b0;
            r_idx            <= '0;
            for (int i = 0; i < MAX_NEIGHBORS; i++) begin
                r_list[i] <= knd_pkg::DIST_ONES;
            end
        end else begin
            if (i_cfg_we) begin
                r_neighbor_count <= i_cfg_wdata;
            end
            if (i_cmd.start) begin
                r_qx <= i_pos_x;
                r_qy <= i_pos_y;
                for (int i = 0; i < MAX_NEIGHBORS; i++) begin
                    r_list[i] <= knd_pkg::DIST_ONES;
                end
            end else if (i_cmd.ins_en) begin
                r_list <= n_list;
            end
            if (i_cmd.emit_start) begin
                r_idx <= '0;
            end else if (i_cmd.out_load) begin
                r_idx <= r_idx + IDX_W'(1);
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.diff_en) begin
            r_dx <= DIF_W'(r_qx) - DIF_W'(i_pos_x);
            r_dy <= DIF_W'(r_qy) - DIF_W'(i_pos_y);
        end
        if (i_cmd.sq_en) begin
            r_sqx <= SQ_W'(mag_x) * SQ_W'(mag_x);
            r_sqy <= SQ_W'(mag_y) * SQ_W'(mag_y);
        end
        if (i_cmd.out_load) begin
            r_out_dist   <= emit_dist;
            r_out_rank   <= knd_pkg::t_rank'(r_idx);
            r_out_filled <= (emit_dist != knd_pkg::DIST_ONES);
            r_out_end    <= (r_idx == last_idx);
        end
    end

    assign o_status.out_free  = !r_out_valid || i_out_ready;
    assign o_status.emit_last = (r_idx == last_idx);

    assign o_out_valid  = r_out_valid;
    assign o_distance   = r_out_dist;
    assign o_rank       = r_out_rank;
    assign o_filled     = r_out_filled;
    assign o_end_of_run = r_out_end;

endmodule

`default_nettype wire

// File: hw/rtl/k_nearest_distance_insertion_top.sv
// A candidate beat is taken, then its squares are registered and its distance is inserted,
// and no new beat is accepted before the insertion is done.
// After a final beat the controller emits the active slots through the output register;
// results then leave at one beat per cycle while the sink is ready.
// Reset (synchronous, active low) empties the list, zeroes the query and sets the count to 1.
`timescale 1ns / 1ps
`default_nettype none
`include "k_nearest_distance_insertion_top_defines.svh"

module k_nearest_distance_insertion_top #(
    parameter int MAX_NEIGHBORS = knd_pkg::MAX_NEIGHBORS_DEF,
    parameter int COORD_BITS    = knd_pkg::COORD_BITS_DEF
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    // Configuration: neighbor count.
    input  wire                          i_cfg_we,
    input  wire  [knd_pkg::CFG_BITS-1:0] i_cfg_wdata,
    // Input channel.
    input  wire                          i_in_valid,
    output logic                         o_in_ready,
    input  wire                          i_cmd,
    input  wire  signed [COORD_BITS-1:0] i_pos_x,
    input  wire  signed [COORD_BITS-1:0] i_pos_y,
    input  wire                          i_final_item,
    // Result channel.
    output logic                         o_out_valid,
    input  wire                          i_out_ready,
    output knd_pkg::t_dist               o_distance,
    output knd_pkg::t_rank               o_rank,
    output logic                         o_filled,
    output logic                         o_end_of_run
);

    // The controller sequences each beat through the datapath. A start beat loads
    // the query point and empties the list in the accept cycle. A candidate beat
    // registers its coordinate differences on acceptance, squares them in the next
    // cycle, and in the cycle after that sums them and inserts the distance into
    // the sorted list with a parallel compare and shift. When the beat was final,
    // the controller walks the active slots and loads one result per cycle, while
    // the output register is free; that register holds a beat until the sink takes
    // it, so the next input beat may be taken while the last result still waits.

    knd_pkg::t_cmd    w_cmd;
    knd_pkg::t_status w_status;

    knd_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_cmd        (i_cmd),
        .i_final_item (i_final_item),
        .i_status     (w_status),
        .o_in_ready   (o_in_ready),
        .o_cmd        (w_cmd)
    );

    knd_dpath #(
        .MAX_NEIGHBORS (MAX_NEIGHBORS),
        .COORD_BITS    (COORD_BITS)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_status     (w_status),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_pos_x      (i_pos_x),
        .i_pos_y      (i_pos_y),
        .i_out_ready  (i_out_ready),
        .o_out_valid  (o_out_valid),
        .o_distance   (o_distance),
        .o_rank       (o_rank),
        .o_filled     (o_filled),
        .o_end_of_run (o_end_of_run)
    );

    // A result beat is only loaded when the output register can take it.
    `KND_ASSERT_NOW(a_load_when_free, i_clk, i_rst_n, w_cmd.out_load, w_status.out_free, "result beat overwritten before it was taken")

    // A candidate keeps the block busy for its arithmetic cycles.
    `KND_ASSERT_NEXT(a_cand_busy, i_clk, i_rst_n, i_in_valid && o_in_ready && (i_cmd == knd_pkg::CMD_CAND), !o_in_ready, "input taken during candidate arithmetic")

    // After a non-final result beat the next one, if present, has the next rank.
    `KND_ASSERT_NEXT(a_rank_step, i_clk, i_rst_n, o_out_valid && i_out_ready && !o_end_of_run, !o_out_valid || (o_rank == $past(o_rank) + 3'd1), "result ranks out of order")

endmodule

`default_nettype wire
